// ===== sv/fwdd_pkg.sv =====
`timescale 1ns / 1ps

package fwdd_pkg;

    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 6;

    // double-dabble correction: a digit of 5 or more gets 3 added before the shift
    localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
    localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

    localparam logic [CHAR_W-1:0]  ASCII_ZERO   = 6'd48;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_CLEAR,
        MODE_CONV,
        MODE_SHIFT
    } t_mode;

endpackage

// ===== sv/fwdd_cell.sv =====
`timescale 1ns / 1ps

module fwdd_cell (
    input  logic                          i_clk,
    input  fwdd_pkg::t_mode               i_mode,
    input  logic                          i_bit,
    input  logic [fwdd_pkg::DIGIT_W-1:0]  i_digit,
    output logic                          o_carry,
    output logic [fwdd_pkg::DIGIT_W-1:0]  o_digit
);
    import fwdd_pkg::*;

    logic [DIGIT_W-1:0] r_digit;
    logic [DIGIT_W-1:0] n_digit;
    logic [DIGIT_W-1:0] w_adj;

    assign w_adj   = (r_digit >= DABBLE_LIMIT) ? r_digit + DABBLE_ADD : r_digit;
    assign o_carry = w_adj[DIGIT_W-1];
    assign o_digit = r_digit;

    always_comb begin
        unique case (i_mode)
            MODE_HOLD:  n_digit = r_digit;
            MODE_CLEAR: n_digit = '0;
            MODE_CONV:  n_digit = {w_adj[DIGIT_W-2:0], i_bit};
            MODE_SHIFT: n_digit = i_digit;
            default:    n_digit = r_digit;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== sv/fixed_width_decimal_digits.sv =====
`timescale 1ns / 1ps

// Channel   Handshake                   Payload
// input     start & !busy               i_value, i_digit_count
// output    o_digit_valid (1 cycle)     o_digit_char, o_last_digit
//
// An item is converted by shift-add-3 through the digit cells, then its digits
// are shifted up the chain, the top cell giving one digit per cycle for the
// last n of them. Busy is high throughout, so no new item is taken before the
// last one is done; the next beat is taken as soon as busy falls.
// A count of zero stops after the conversion and emits no beat.
// Reset is synchronous, active low, and returns the block to idle.
// Output beats are not held off by the receiver; each lasts one cycle.

module fixed_width_decimal_digits #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic [VALUE_WIDTH-1:0]        i_value,
    input  logic [3:0]                    i_digit_count,
    output logic                          busy,
    output logic                          o_digit_valid,
    output logic [fwdd_pkg::CHAR_W-1:0]   o_digit_char,
    output logic                          o_last_digit
);
    import fwdd_pkg::*;

    localparam int CW  = $clog2(MAX_DIGITS + 1);
    localparam int KW  = (CW > 4) ? CW : 4;
    localparam int BW  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_value;
    logic [BW-1:0]          r_bits;
    logic [CW-1:0]          r_num;
    logic [CW-1:0]          r_skip;

    logic [KW-1:0]          w_cnt_ext;
    logic [CW-1:0]          w_n;
    t_mode                  w_mode;
    logic                   w_accept;

    logic                   w_carry [MAX_DIGITS];
    logic [DIGIT_W-1:0]     w_digit [MAX_DIGITS];

    assign w_accept  = start && !busy;
    assign busy      = (r_state != ST_IDLE);
    assign w_cnt_ext = KW'(i_digit_count);
    assign w_n       = (w_cnt_ext > KW'(MAX_DIGITS)) ? CW'(MAX_DIGITS) : CW'(w_cnt_ext);

    always_comb begin
        unique case (r_state)
            ST_IDLE: w_mode = w_accept ? MODE_CLEAR : MODE_HOLD;
            ST_CONV: w_mode = MODE_CONV;
            ST_SKIP: w_mode = MODE_SHIFT;
            ST_EMIT: w_mode = MODE_SHIFT;
            default: w_mode = MODE_HOLD;
        endcase
    end

    // cell 0 holds the least significant digit; the top cell feeds the output
    for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
        if (k == 0) begin : g_first
            fwdd_cell u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode),
                .i_bit   (r_value[VALUE_WIDTH-1]),
                .i_digit ('0),
                .o_carry (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end else begin : g_rest
            fwdd_cell u_cell (
                .i_clk   (i_clk),
                .i_mode  (w_mode),
                .i_bit   (w_carry[k-1]),
                .i_digit (w_digit[k-1]),
                .o_carry (w_carry[k]),
                .o_digit (w_digit[k])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            o_digit_valid <= 1'b0;
        end else begin
            o_digit_valid <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_value <= i_value;
                        r_bits  <= BW'(VALUE_WIDTH - 1);
                        r_num   <= w_n;
                        r_skip  <= CW'(MAX_DIGITS) - w_n;
                        r_state <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    r_value <= {r_value[VALUE_WIDTH-2:0], 1'b0};
                    r_bits  <= r_bits - 1'b1;
                    if (r_bits == '0) begin
                        priority if (r_num == '0) begin
                            r_state <= ST_IDLE;
                        end else if (r_skip == '0) begin
                            r_state <= ST_EMIT;
                        end else begin
                            r_state <= ST_SKIP;
                        end
                    end
                end
                ST_SKIP: begin
                    // digits above the requested count are shifted off unseen
                    r_skip <= r_skip - 1'b1;
                    if (r_skip == CW'(1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    o_digit_valid <= 1'b1;
                    o_digit_char  <= ASCII_ZERO + CHAR_W'(w_digit[MAX_DIGITS-1]);
                    o_last_digit  <= (r_num == CW'(1));
                    r_num         <= r_num - 1'b1;
                    if (r_num == CW'(1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/fwdd_chk.sv =====
`timescale 1ns / 1ps

module fwdd_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         o_digit_valid,
    input logic [fwdd_pkg::CHAR_W-1:0]  o_digit_char,
    input logic                         o_last_digit
);
    import fwdd_pkg::*;

    // an accepted item always keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accepted item");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid |-> (o_digit_char >= ASCII_ZERO) && (o_digit_char <= ASCII_ZERO + 6'd9))
        else $error("digit character out of range");

    // digits of one run come on consecutive cycles
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid && !o_last_digit |=> o_digit_valid)
        else $error("gap inside a digit run");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid && o_last_digit |=> !o_digit_valid)
        else $error("beat after last digit");

    a_last_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_digit_valid && !o_last_digit |-> busy)
        else $error("non-final digit while idle");

endmodule

bind fixed_width_decimal_digits fwdd_chk u_fwdd_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_digit_valid (o_digit_valid),
    .o_digit_char  (o_digit_char),
    .o_last_digit  (o_last_digit)
);
